[hw/rtl/fdc_pkg.sv]
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types and constants for the debounced fan speed controller.
// ----------------------------------------------------------------------------
package fdc_pkg;

    // Event codes carried by a request
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_POWER  = 2'd1,
        OP_SPEED  = 2'd2,
        OP_SAMPLE = 2'd3
    } op_t;

    // Fan modes
    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_LOW  = 2'd1,
        MODE_HIGH = 2'd2
    } mode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_LOCKOUT   = 2'd0,
        REG_ADC_INTVL = 2'd1,
        REG_HIGH_DUTY = 2'd2
    } reg_idx_t;

    localparam int LOCKOUT_W = 10;
    localparam int LOCK_W    = LOCKOUT_W + 1;
    localparam int TICK_W    = 8;
    localparam int DUTY_W    = 8;
    localparam int CFG_W     = LOCKOUT_W;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RST   = 10'd200;
    localparam logic [TICK_W-1:0]    ADC_INTVL_RST = 8'd10;
    localparam logic [DUTY_W-1:0]    HIGH_DUTY_RST = 8'd255;
    localparam logic [DUTY_W-1:0]    LOW_SPEED_RST = 8'd128;

endpackage

[hw/rtl/fdc_if.sv]
// ----------------------------------------------------------------------------
// fdc_if
// Request and response channels of the fan speed controller.
// ----------------------------------------------------------------------------
interface fdc_req_if;
    logic              valid;
    logic              ready;
    fdc_pkg::op_t      op;
    logic [7:0]        sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

interface fdc_rsp_if;
    logic              valid;
    logic              ready;
    fdc_pkg::mode_t    fan_mode;
    logic [7:0]        duty;
    logic              press_taken;
    logic              adc_start;

    modport source (output valid, output fan_mode, output duty, output press_taken,
                    output adc_start, input ready);
    modport sink   (input valid, input fan_mode, input duty, input press_taken,
                    input adc_start, output ready);
endinterface

[hw/rtl/fdc_lockout.sv]
// ----------------------------------------------------------------------------
// fdc_lockout
// Per-button lockout counter: counts ticks up to lockout+1, takes a press
// once the lockout is reached and clears on a taken press.
// ----------------------------------------------------------------------------
module fdc_lockout (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick,
    input  logic                                press,
    input  logic [fdc_pkg::LOCKOUT_W-1:0]       lockout_ticks,
    output logic                                taken
);

    logic [fdc_pkg::LOCK_W-1:0] lock_reg;
    logic [fdc_pkg::LOCK_W-1:0] lock_next;
    logic [fdc_pkg::LOCK_W-1:0] limit;

    assign limit = {1'b0, lockout_ticks} + fdc_pkg::LOCK_W'(1);
    assign taken = press && (lock_reg >= {1'b0, lockout_ticks});

    // Advance on a tick until saturated, clear on a taken press
    always_comb
    begin
        lock_next = lock_reg;
        if (tick && (lock_reg < limit))
        begin
            lock_next = lock_reg + fdc_pkg::LOCK_W'(1);
        end
        else if (taken)
        begin
            lock_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_reg <= '0;
        end
        else
        begin
            lock_reg <= lock_next;
        end
    end

endmodule

[hw/rtl/fdc_adc_timer.sv]
// ----------------------------------------------------------------------------
// fdc_adc_timer
// Tick counter that requests an ADC conversion every interval+1 ticks; at 255 it never fires.
// ----------------------------------------------------------------------------
module fdc_adc_timer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick,
    input  logic [fdc_pkg::TICK_W-1:0]       adc_interval,
    output logic                             adc_start
);

    logic [fdc_pkg::TICK_W-1:0] count_reg;
    logic [fdc_pkg::TICK_W-1:0] count_next;
    logic [fdc_pkg::TICK_W-1:0] count_inc;

    assign count_inc = count_reg + fdc_pkg::TICK_W'(1);
    assign adc_start = tick && (count_inc > adc_interval);

    // Advance on a tick, restart after a conversion request
    always_comb
    begin
        count_next = count_reg;
        if (adc_start)
        begin
            count_next = '0;
        end
        else if (tick)
        begin
            count_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/debounced_fan_speed_controller_top.sv]
// A request's response is registered and presented in the cycle after it is accepted.
// One request per cycle unless rsp stalls; the response register frees as it is
// taken, so a request is accepted in the same cycle the previous response leaves.
// All state updates for a request settle in the accept cycle.
// Reset (rst_n low, asynchronous): mode off, duty 0, low speed 128, counters 0,
// configuration at lockout 200, ADC interval 10, high duty 255.
// ----------------------------------------------------------------------------
// debounced_fan_speed_controller_top
// Three-mode fan controller with debounced buttons and an ADC start timer.
// ----------------------------------------------------------------------------
module debounced_fan_speed_controller_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [1:0]                       cfg_index,
    input  logic [fdc_pkg::CFG_W-1:0]        cfg_data,
    fdc_req_if.sink                          req,
    fdc_rsp_if.source                        rsp
);

    // Configuration registers
    logic [fdc_pkg::LOCKOUT_W-1:0] lockout_reg;
    logic [fdc_pkg::TICK_W-1:0]    adc_intvl_reg;
    logic [fdc_pkg::DUTY_W-1:0]    high_duty_reg;

    // Controller state
    fdc_pkg::mode_t                mode_reg;
    fdc_pkg::mode_t                mode_next;
    logic [fdc_pkg::DUTY_W-1:0]    duty_reg;
    logic [fdc_pkg::DUTY_W-1:0]    duty_next;
    logic [fdc_pkg::DUTY_W-1:0]    low_speed_reg;

    // Response register
    logic                          rsp_valid_reg;
    logic                          taken_reg;
    logic                          start_reg;

    logic accept;
    logic is_tick;
    logic is_power;
    logic is_speed;
    logic is_sample;
    logic power_taken;
    logic speed_taken;
    logic adc_start;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_tick   = accept && (req.op == fdc_pkg::OP_TICK);
    assign is_power  = accept && (req.op == fdc_pkg::OP_POWER);
    assign is_speed  = accept && (req.op == fdc_pkg::OP_SPEED);
    assign is_sample = accept && (req.op == fdc_pkg::OP_SAMPLE);

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg   <= fdc_pkg::LOCKOUT_RST;
            adc_intvl_reg <= fdc_pkg::ADC_INTVL_RST;
            high_duty_reg <= fdc_pkg::HIGH_DUTY_RST;
        end
        else if (cfg_wr_en)
        begin
            case (fdc_pkg::reg_idx_t'(cfg_index))
                fdc_pkg::REG_LOCKOUT:   lockout_reg   <= cfg_data;
                fdc_pkg::REG_ADC_INTVL: adc_intvl_reg <= cfg_data[fdc_pkg::TICK_W-1:0];
                fdc_pkg::REG_HIGH_DUTY: high_duty_reg <= cfg_data[fdc_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    fdc_lockout u_power_lock (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (is_tick),
        .press         (is_power),
        .lockout_ticks (lockout_reg),
        .taken         (power_taken)
    );

    fdc_lockout u_speed_lock (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (is_tick),
        .press         (is_speed),
        .lockout_ticks (lockout_reg),
        .taken         (speed_taken)
    );

    fdc_adc_timer u_adc_timer (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (is_tick),
        .adc_interval (adc_intvl_reg),
        .adc_start    (adc_start)
    );

    // Pick the new mode on a taken press, then its duty
    always_comb
    begin
        mode_next = mode_reg;
        duty_next = duty_reg;
        if (power_taken)
        begin
            mode_next = (mode_reg == fdc_pkg::MODE_OFF) ? fdc_pkg::MODE_LOW
                                                        : fdc_pkg::MODE_OFF;
        end
        else if (speed_taken)
        begin
            case (mode_reg)
                fdc_pkg::MODE_LOW:  mode_next = fdc_pkg::MODE_HIGH;
                fdc_pkg::MODE_HIGH: mode_next = fdc_pkg::MODE_LOW;
                default:            mode_next = fdc_pkg::MODE_OFF;
            endcase
        end
        if (power_taken || speed_taken)
        begin
            case (mode_next)
                fdc_pkg::MODE_LOW:  duty_next = low_speed_reg;
                fdc_pkg::MODE_HIGH: duty_next = high_duty_reg;
                default:            duty_next = '0;
            endcase
        end
    end

    // Hold controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= fdc_pkg::MODE_OFF;
            duty_reg      <= '0;
            low_speed_reg <= fdc_pkg::LOW_SPEED_RST;
        end
        else
        begin
            mode_reg <= mode_next;
            duty_reg <= duty_next;
            if (is_sample)
            begin
                low_speed_reg <= req.sample;
            end
        end
    end

    // Response valid: set on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Response flags follow the accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            taken_reg <= power_taken || speed_taken;
            start_reg <= adc_start;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.fan_mode    = mode_reg;
    assign rsp.duty        = duty_reg;
    assign rsp.press_taken = taken_reg;
    assign rsp.adc_start   = start_reg;

    // Checks
    a_rsp_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.valid)
        else $error("response missing after accepted request");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.press_taken && rsp.adc_start))
        else $error("press and ADC start flagged together");

    a_off_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == fdc_pkg::MODE_OFF) |-> (duty_reg == '0))
        else $error("nonzero duty while off");

    a_state_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(mode_reg) && $stable(duty_reg))
        else $error("mode or duty changed without a request");

endmodule

[verif/debounced_fan_speed_controller_top_test.sv]
// ----------------------------------------------------------------------------
// debounced_fan_speed_controller_top_test
// Self-checking bench for the fan controller. A short table of directed
// requests covers the button lockouts, mode changes, duty sources and ADC
// timer extremes. Several randomized phases follow, each under its own
// register setting. Traffic is bursty on the request side, and the response
// side stalls on a pattern of its own. Every response is checked against a
// cycle-free model of the controller state or against a status fixed by hand.
// ----------------------------------------------------------------------------
module debounced_fan_speed_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // One response of the controller
    typedef struct packed {
        fdc_pkg::mode_t fan_mode;
        logic [7:0]     duty;
        logic           press_taken;
        logic           adc_start;
    } fan_status_t;

    // Expected status fixed by hand, or left to the model
    typedef struct packed {
        bit          pinned;
        fan_status_t status;
    } pin_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        fdc_pkg::op_t              op;
        logic [7:0]                sample;
        fdc_pkg::reg_idx_t         idx;
        logic [fdc_pkg::CFG_W-1:0] data;
        bit                        pinned;
        fan_status_t               status;
    } dir_row_t;

    localparam int          DIR_ROWS = 23;
    localparam fan_status_t OFF_IDLE = '{fdc_pkg::MODE_OFF, 8'd0, 1'b0, 1'b0};

    // Directed table: reset lockout, zero lockout, duty sources, timer extremes
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{ROW_REQ, fdc_pkg::OP_POWER, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b1, OFF_IDLE},
        '{ROW_REQ, fdc_pkg::OP_SPEED, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b1, OFF_IDLE},
        '{ROW_REQ, fdc_pkg::OP_SAMPLE, 8'd255, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b1,
          OFF_IDLE},
        '{ROW_REQ, fdc_pkg::OP_TICK, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b1, OFF_IDLE},
        '{ROW_CFG, fdc_pkg::OP_TICK, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b0, OFF_IDLE},
        '{ROW_REQ, fdc_pkg::OP_SPEED, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b1,
          '{fdc_pkg::MODE_OFF, 8'd0, 1'b1, 1'b0}},
        '{ROW_REQ, fdc_pkg::OP_POWER, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b1,
          '{fdc_pkg::MODE_LOW, 8'd255, 1'b1, 1'b0}},
        '{ROW_REQ, fdc_pkg::OP_SAMPLE, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b0, OFF_IDLE},
        '{ROW_REQ, fdc_pkg::OP_POWER, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b0, OFF_IDLE},
        '{ROW_REQ, fdc_pkg::OP_POWER, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b0, OFF_IDLE},
        '{ROW_REQ, fdc_pkg::OP_SPEED, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b0, OFF_IDLE},
        '{ROW_CFG, fdc_pkg::OP_TICK, 8'd0, fdc_pkg::REG_HIGH_DUTY, 10'd0, 1'b0, OFF_IDLE},
        '{ROW_REQ, fdc_pkg::OP_SPEED, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b0, OFF_IDLE},
        '{ROW_REQ, fdc_pkg::OP_SPEED, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b0, OFF_IDLE},
        '{ROW_CFG, fdc_pkg::OP_TICK, 8'd0, fdc_pkg::REG_ADC_INTVL, 10'd0, 1'b0, OFF_IDLE},
        '{ROW_REQ, fdc_pkg::OP_TICK, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b0, OFF_IDLE},
        '{ROW_REQ, fdc_pkg::OP_TICK, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b0, OFF_IDLE},
        '{ROW_CFG, fdc_pkg::OP_TICK, 8'd0, fdc_pkg::REG_ADC_INTVL, 10'd255, 1'b0,
          OFF_IDLE},
        '{ROW_REQ, fdc_pkg::OP_TICK, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b0, OFF_IDLE},
        '{ROW_CFG, fdc_pkg::OP_TICK, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd1023, 1'b0,
          OFF_IDLE},
        '{ROW_REQ, fdc_pkg::OP_POWER, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b0, OFF_IDLE},
        '{ROW_REQ, fdc_pkg::OP_SAMPLE, 8'h5a, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b0,
          OFF_IDLE},
        '{ROW_REQ, fdc_pkg::OP_SPEED, 8'd0, fdc_pkg::REG_LOCKOUT, 10'd0, 1'b0, OFF_IDLE}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    fdc_pkg::reg_idx_t         cfg_index;
    logic [fdc_pkg::CFG_W-1:0] cfg_data;

    fdc_req_if req();
    fdc_rsp_if rsp();

    debounced_fan_speed_controller_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    // Model copy of the registers and controller state, at reset values
    logic [fdc_pkg::LOCKOUT_W-1:0] lockout_lim  = fdc_pkg::LOCKOUT_RST;
    logic [fdc_pkg::TICK_W-1:0]    adc_every    = fdc_pkg::ADC_INTVL_RST;
    logic [fdc_pkg::DUTY_W-1:0]    fast_duty    = fdc_pkg::HIGH_DUTY_RST;
    fdc_pkg::mode_t                fan_mode_q   = fdc_pkg::MODE_OFF;
    logic [fdc_pkg::LOCK_W-1:0]    pwr_hold_cnt = '0;
    logic [fdc_pkg::LOCK_W-1:0]    spd_hold_cnt = '0;
    logic [fdc_pkg::TICK_W-1:0]    ms_cnt       = '0;
    logic [fdc_pkg::DUTY_W-1:0]    pot_level    = fdc_pkg::LOW_SPEED_RST;
    logic [fdc_pkg::DUTY_W-1:0]    duty_q       = '0;

    pin_t        pin_q[$];
    fan_status_t fan_status_q[$];
    int          mismatch_cnt = 0;
    int          burst_left   = 0;
    logic [7:0]  stall_pat    = 8'hff;
    logic [5:0]  stall_cyc    = '0;

    // Enter a mode and load the duty that goes with it
    function automatic void switch_mode(fdc_pkg::mode_t m);
        fan_mode_q = m;
        case (m)
            fdc_pkg::MODE_LOW:  duty_q = pot_level;
            fdc_pkg::MODE_HIGH: duty_q = fast_duty;
            default:            duty_q = '0;
        endcase
    endfunction

    // Advance the model by one event and return the status it leaves
    function automatic fan_status_t next_fan_status(fdc_pkg::op_t op, logic [7:0] smp);
        logic taken;
        logic start;
        taken = 1'b0;
        start = 1'b0;
        case (op)
            fdc_pkg::OP_TICK:
            begin
                if (pwr_hold_cnt < lockout_lim + 1) pwr_hold_cnt = pwr_hold_cnt + 1'b1;
                if (spd_hold_cnt < lockout_lim + 1) spd_hold_cnt = spd_hold_cnt + 1'b1;
                ms_cnt = ms_cnt + 1'b1;
                if (ms_cnt > adc_every)
                begin
                    start  = 1'b1;
                    ms_cnt = '0;
                end
            end
            fdc_pkg::OP_POWER:
            begin
                if (pwr_hold_cnt >= lockout_lim)
                begin
                    pwr_hold_cnt = '0;
                    taken        = 1'b1;
                    switch_mode(fan_mode_q == fdc_pkg::MODE_OFF ? fdc_pkg::MODE_LOW
                                                                : fdc_pkg::MODE_OFF);
                end
            end
            fdc_pkg::OP_SPEED:
            begin
                if (spd_hold_cnt >= lockout_lim)
                begin
                    spd_hold_cnt = '0;
                    taken        = 1'b1;
                    if (fan_mode_q == fdc_pkg::MODE_LOW)
                        switch_mode(fdc_pkg::MODE_HIGH);
                    else if (fan_mode_q == fdc_pkg::MODE_HIGH)
                        switch_mode(fdc_pkg::MODE_LOW);
                    else
                        switch_mode(fdc_pkg::MODE_OFF);
                end
            end
            default: pot_level = smp;
        endcase
        return '{fan_mode_q, duty_q, taken, start};
    endfunction

    // Clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Response stall: pick a new pattern each time stall_cyc wraps, often no stall at all
    always @(posedge clk)
    begin
        stall_cyc <= stall_cyc + 1'b1;
        if (stall_cyc == '0)
            stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
        rsp.ready <= stall_pat[stall_cyc[2:0]];
    end

    // Predict on each accepted request, check each accepted response
    always @(posedge clk)
    begin : check_blk
        fan_status_t pred;
        fan_status_t want;
        fan_status_t got;
        pin_t        tag;
        if (rst_n && req.valid && req.ready)
        begin
            pred = next_fan_status(req.op, req.sample);
            tag  = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
            fan_status_q.push_back(tag.pinned ? tag.status : pred);
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{rsp.fan_mode, rsp.duty, rsp.press_taken, rsp.adc_start};
            if (fan_status_q.size() == 0)
            begin
                $error("response with no request pending");
                mismatch_cnt++;
            end
            else
            begin
                want = fan_status_q.pop_front();
                if (got.fan_mode !== want.fan_mode)
                begin
                    $error("fan_mode: expected %0d, got %0d", want.fan_mode, got.fan_mode);
                    mismatch_cnt++;
                end
                if (got.duty !== want.duty)
                begin
                    $error("duty: expected %0d, got %0d", want.duty, got.duty);
                    mismatch_cnt++;
                end
                if (got.press_taken !== want.press_taken)
                begin
                    $error("press_taken: expected %0d, got %0d",
                           want.press_taken, got.press_taken);
                    mismatch_cnt++;
                end
                if (got.adc_start !== want.adc_start)
                begin
                    $error("adc_start: expected %0d, got %0d",
                           want.adc_start, got.adc_start);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Drop valid and hold until every request has answered
    task automatic settle();
        req.valid <= 1'b0;
        do @(posedge clk); while (pin_q.size() != 0 || fan_status_q.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // Write one register and mirror it into the model
    task automatic write_reg(fdc_pkg::reg_idx_t idx, logic [fdc_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            fdc_pkg::REG_LOCKOUT:   lockout_lim = val;
            fdc_pkg::REG_ADC_INTVL: adc_every   = val[fdc_pkg::TICK_W-1:0];
            fdc_pkg::REG_HIGH_DUTY: fast_duty   = val[fdc_pkg::DUTY_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Issue one request in a burst, with a random gap between bursts
    task automatic send_request(fdc_pkg::op_t op, logic [7:0] smp, bit pinned,
                                fan_status_t status);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pin_q.push_back('{pinned, status});
        req.valid  <= 1'b1;
        req.op     <= op;
        req.sample <= smp;
        do @(posedge clk); while (!req.ready);
    endtask

    // Run limit
    initial
    begin
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : stim_blk
        logic [fdc_pkg::CFG_W-1:0] lock_v;
        logic [7:0]                intvl_v;
        logic [7:0]                duty_v;
        int                        n_items;
        int                        tick_pct;
        fdc_pkg::op_t              op_v;
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = fdc_pkg::REG_LOCKOUT;
        cfg_data   = '0;
        req.valid  = 1'b0;
        req.op     = fdc_pkg::OP_TICK;
        req.sample = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (DIR_TAB[i])
        begin
            if (DIR_TAB[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(DIR_TAB[i].idx, DIR_TAB[i].data);
            end
            else
                send_request(DIR_TAB[i].op, DIR_TAB[i].sample, DIR_TAB[i].pinned,
                             DIR_TAB[i].status);
        end

        // Random phases: extremes first, then small lockouts that let presses through
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0:
                begin
                    lock_v  = 10'd1;
                    intvl_v = 8'd254;
                    duty_v  = 8'd255;
                end
                1:
                begin
                    lock_v  = 10'd1023;
                    intvl_v = 8'd0;
                    duty_v  = 8'd0;
                end
                2:
                begin
                    lock_v  = 10'd5;
                    intvl_v = 8'd255;
                    duty_v  = 8'($urandom);
                end
                default:
                begin
                    lock_v  = 10'($urandom_range(1, 40));
                    intvl_v = 8'($urandom_range(0, 30));
                    duty_v  = 8'($urandom);
                end
            endcase
            settle();
            write_reg(fdc_pkg::REG_LOCKOUT, lock_v);
            write_reg(fdc_pkg::REG_ADC_INTVL, {2'b00, intvl_v});
            write_reg(fdc_pkg::REG_HIGH_DUTY, {2'b00, duty_v});
            // Tick-heavy phase lets the timer wrap when it can never fire
            n_items  = (p == 2) ? 300 : 150;
            tick_pct = (p == 2) ? 90 : 50;
            for (int k = 0; k < n_items; k++)
            begin
                if (p == 3 && k == 75)
                    settle();
                if ($urandom_range(0, 99) < tick_pct)
                    op_v = fdc_pkg::OP_TICK;
                else
                    op_v = fdc_pkg::op_t'($urandom_range(1, 3));
                send_request(op_v, 8'($urandom), 1'b0, '0);
            end
        end

        settle();
        repeat (4) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
hw/rtl/fdc_pkg.sv
hw/rtl/fdc_if.sv
hw/rtl/fdc_lockout.sv
hw/rtl/fdc_adc_timer.sv
hw/rtl/debounced_fan_speed_controller_top.sv
verif/debounced_fan_speed_controller_top_test.sv
